// ===== src/srpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper ramp period generator package
// Shared types, constants and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none
package srpg_pkg;
    localparam int unsigned PERIOD_MAX_DEF   = 60000;
    localparam int unsigned PERIOD_MIN_DEF   = 1000;
    localparam int unsigned PRESCALE_TOP_DEF = 7;

    localparam logic [63:0] TEN_K_Q14   = 64'd163840000;
    localparam logic [63:0] TEN_K_Q15   = 64'd327680000;
    localparam logic [63:0] TEN_K_Q13   = 64'd81920000;
    localparam logic [63:0] MARK_LIMIT  = 64'd2146959360;
    localparam logic [63:0] CROSS_LIMIT = 64'd1073479680;
    localparam logic [63:0] GONE_LIMIT  = 64'd536739840;
    localparam logic [63:0] M31         = 64'h7FFF_FFFF;
    localparam logic [63:0] M32         = 64'hFFFF_FFFF;

    localparam logic [2:0] REG_TARGET_VEL = 3'd0;
    localparam logic [2:0] REG_ACCEL      = 3'd1;
    localparam logic [2:0] REG_MOVE_DIST  = 3'd2;
    localparam logic [2:0] REG_DECEL_DIST = 3'd3;
    localparam logic [2:0] REG_DECEL_VEL  = 3'd4;
    localparam logic [2:0] REG_STEP_LEN   = 3'd5;
    localparam logic [2:0] REG_TICK_PER   = 3'd6;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PTS,
        ST_V,
        ST_V_W,
        ST_A,
        ST_T,
        ST_DV,
        ST_NV,
        ST_PNT,
        ST_PNT_W,
        ST_NP,
        ST_LIM,
        ST_PH,
        ST_X,
        ST_X_W,
        ST_STEP,
        ST_ODO,
        ST_REM,
        ST_OUT
    } state_t;

    function automatic logic [63:0] sat_top(input logic [63:0] v, input logic [63:0] top);
        return (v > top) ? top : v;
    endfunction
endpackage
`default_nettype wire

// ===== src/srpg_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// 64-bit unsigned radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module srpg_div
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire srpg_pkg::div_req_t req,
    output srpg_pkg::div_rsp_t      rsp
);
    import srpg_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

// ===== src/stepper_ramp_period_generator.sv =====
// ----------------------------------------------------------------------------
// Stepper ramp period generator
// One stepper channel: trapezoidal velocity ramp, step period and odometers.
// ----------------------------------------------------------------------------
// Each tick beat passes from acceptance to the result register through a
// sequencer: it runs up to three 64-bit divisions through one shared restoring
// divider (two when the ramp ends at standstill, one when the velocity already
// sits at its target), does the divisions by 10000 as reciprocal multiplies and
// runs a handful of 32x32 multiplies and compares, one per cycle. The result
// beat is held in an output register; the next tick or register write is taken
// once that beat has gone, and a register write wins over a tick in the same
// cycle.
`default_nettype none
module stepper_ramp_period_generator
#(
    parameter int unsigned PERIOD_MAX   = srpg_pkg::PERIOD_MAX_DEF,
    parameter int unsigned PERIOD_MIN   = srpg_pkg::PERIOD_MIN_DEF,
    parameter int unsigned PRESCALE_TOP = srpg_pkg::PRESCALE_TOP_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // steering_gain[30:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pwm_period, pwm_compare, prescale, velocity, step_distance, travelled,
    // remaining, mark_distance, cross_distance (from bit 0 up)
    output logic [223:0]      m_tdata
);
    import srpg_pkg::*;

    localparam logic [63:0] NP_MAX = 64'(PERIOD_MAX) << 14;
    localparam logic [63:0] NP_MIN = 64'(PERIOD_MIN) << 14;
    localparam logic [63:0] HI     = 64'(PERIOD_MAX) << 13;
    localparam logic [63:0] LO0    = 64'(PERIOD_MIN) << 13;
    localparam logic [2:0]  PTOP   = 3'(PRESCALE_TOP);
    localparam logic [31:0] RECIP_10K = 32'hD1B7_1759;

    state_t state_reg, state_next;

    logic [30:0] acc_reg, dv_vel_reg, sl_reg;
    logic [31:0] md_reg, dd_reg;
    logic [15:0] tp_reg;
    logic [63:0] np_reg, nv_reg, tgt_reg;
    logic [2:0]  ps_reg;
    logic        armed_reg;
    logic [63:0] gone_reg, mark_reg, cross_reg;

    // per-tick scratch
    logic [63:0] gain_reg, scale_reg, wnp_reg, wnv_reg, v_reg, dvl_reg, pts_reg;
    logic [31:0] a_reg, t_reg, pnt_reg;
    logic [63:0] x_reg, step_reg, ph_reg;
    logic [2:0]  clk_reg;
    logic        rising_reg;
    logic [63:0] rem_reg;
    logic [223:0] out_reg;
    logic         ov_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    srpg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic idle;
    assign idle      = (state_reg == ST_IDLE) && !ov_reg;
    assign s_tready  = idle && !cfg_valid;
    assign cfg_ready = idle;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = out_reg;

    logic [63:0] period, lo, nvr, np1, rem_sat, div10k_prod;
    logic [31:0] div10k_in, quo10k;
    logic signed [63:0] rs;

    always_comb
    begin
        state_next = state_reg;
        dreq       = '0;
        div10k_in  = wnp_reg[31:0];
        lo         = LO0 >> clk_reg;
        period     = (ph_reg >> 13) & 64'hFFFF;
        rs         = $signed({{32{md_reg[31]}}, md_reg}) - $signed(gone_reg << 2);
        rem_sat    = (rs > 64'sh7FFFFFFF) ? 64'h7FFFFFFF
                     : ((rs < -64'sh80000000) ? 64'hFFFFFFFF80000000 : rs);
        np1        = (wnp_reg[31:0] * gain_reg[30:0]) >> 18;
        if (rising_reg)
            nvr = (v_reg + dvl_reg >= tgt_reg) ? tgt_reg : v_reg + dvl_reg;
        else
            nvr = (v_reg <= dvl_reg + tgt_reg) ? tgt_reg : v_reg - dvl_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid && s_tready) state_next = (nv_reg != tgt_reg) ? ST_PTS : ST_PH;
            ST_PTS:   state_next = ST_V;
            ST_V:
            begin
                dreq = '{start: 1'b1, num: scale_reg << 17,
                         den: (pts_reg << 3) << clk_reg};
                state_next = ST_V_W;
            end
            ST_V_W:   if (drsp.done) state_next = ST_A;
            ST_A:
            begin
                div10k_in  = {1'b0, acc_reg};
                state_next = ST_T;
            end
            ST_T:
            begin
                div10k_in  = {1'b0, tp_reg, 15'd0};
                state_next = ST_DV;
            end
            ST_DV:    state_next = ST_NV;
            ST_NV:    state_next = (nvr == 64'd0) ? ST_LIM : ST_PNT;
            ST_PNT:
            begin
                dreq = '{start: 1'b1, num: scale_reg << 17, den: wnv_reg};
                state_next = ST_PNT_W;
            end
            ST_PNT_W: if (drsp.done) state_next = ST_NP;
            ST_NP:    state_next = ST_LIM;
            ST_LIM:   state_next = ST_PH;
            ST_PH:    state_next = ST_X;
            ST_X:
            begin
                dreq = '{start: 1'b1, num: 64'(tp_reg) << 28, den: wnp_reg};
                state_next = ST_X_W;
            end
            ST_X_W:   if (drsp.done) state_next = ST_STEP;
            ST_STEP:  state_next = ST_ODO;
            ST_ODO:   state_next = ST_REM;
            ST_REM:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
        div10k_prod = 64'(div10k_in) * 64'(RECIP_10K);
        quo10k      = 32'(div10k_prod >> 45);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            acc_reg <= '0; md_reg <= '0; dd_reg <= '0;
            dv_vel_reg <= '0; sl_reg <= '0; tp_reg <= 16'd1;
            np_reg <= NP_MAX; nv_reg <= '0; tgt_reg <= '0; ps_reg <= '0;
            armed_reg <= 1'b0; gone_reg <= '0; mark_reg <= '0; cross_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET_VEL: tgt_reg <= {33'd0, cfg_data[30:0]};
                    REG_ACCEL:      acc_reg <= cfg_data[30:0];
                    REG_MOVE_DIST:  md_reg <= cfg_data;
                    REG_DECEL_DIST:
                    begin
                        dd_reg    <= cfg_data;
                        armed_reg <= 1'b1;
                    end
                    REG_DECEL_VEL:  dv_vel_reg <= cfg_data[30:0];
                    REG_STEP_LEN:   sl_reg <= cfg_data[30:0];
                    REG_TICK_PER:   tp_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end
            case (state_reg)
                ST_PH:
                begin
                    np_reg <= wnp_reg;
                    nv_reg <= wnv_reg;
                    ps_reg <= clk_reg;
                end
                ST_ODO:
                begin
                    mark_reg  <= (mark_reg > MARK_LIMIT) ? mark_reg
                                 : sat_top(mark_reg + step_reg, M31);
                    cross_reg <= (cross_reg > CROSS_LIMIT) ? cross_reg
                                 : sat_top(cross_reg + (step_reg >> 2), M31);
                    gone_reg  <= (gone_reg > GONE_LIMIT) ? gone_reg
                                 : sat_top(gone_reg + (step_reg >> 2), M31);
                end
                ST_REM:
                begin
                    if (armed_reg && ($signed({{32{dd_reg[31]}}, dd_reg}) >= $signed(rem_sat)))
                    begin
                        tgt_reg   <= {33'd0, dv_vel_reg};
                        armed_reg <= 1'b0;
                    end
                end
                ST_OUT:   ov_reg <= 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                gain_reg   <= {33'd0, s_tdata[30:0]};
                scale_reg  <= 64'(sl_reg) * 64'd10000;
                wnp_reg    <= np_reg;
                wnv_reg    <= nv_reg;
                clk_reg    <= ps_reg;
                rising_reg <= nv_reg < tgt_reg;
            end
            ST_PTS:   pts_reg <= {32'd0, quo10k};
            ST_V_W:   if (drsp.done) v_reg <= (pts_reg == 64'd0) ? M31 : sat_top(drsp.quo, M31);
            ST_A:     a_reg <= quo10k;
            ST_T:     t_reg <= quo10k;
            ST_DV:    dvl_reg <= (64'(a_reg) * 64'(t_reg)) >> 13;
            ST_NV:    wnv_reg <= nvr;
            ST_PNT_W: if (drsp.done) pnt_reg <= 32'(sat_top(drsp.quo, M32));
            ST_NP:    wnp_reg <= sat_top(((TEN_K_Q13 >> clk_reg) * 64'(pnt_reg)) >> 16, M32);
            default:  ;
        endcase
        if (state_reg == ST_NV && nvr == 64'd0)
            wnp_reg <= NP_MAX;
        if (state_reg == ST_LIM)
        begin
            if (rising_reg)
            begin
                if (wnp_reg <= NP_MIN)
                begin
                    if (clk_reg > 3'd0)
                    begin
                        wnp_reg <= NP_MIN << 1;
                        clk_reg <= clk_reg - 3'd1;
                    end
                    else
                        wnp_reg <= NP_MIN;
                end
            end
            else if (wnp_reg >= NP_MAX)
            begin
                if (clk_reg < PTOP)
                begin
                    wnp_reg <= NP_MAX >> 1;
                    clk_reg <= clk_reg + 3'd1;
                end
                else
                    wnp_reg <= NP_MAX;
            end
        end
        if (state_reg == ST_PH)
            ph_reg <= (np1 >= HI) ? HI : ((np1 <= lo) ? lo : np1);
        if (state_reg == ST_X_W && drsp.done)
            x_reg <= ((wnp_reg == 64'd0) ? M31 : sat_top(drsp.quo, M31)) >> clk_reg;
        if (state_reg == ST_STEP)
            step_reg <= sat_top((64'(sl_reg) * 64'(x_reg[30:0])) >> 14, M31);
        if (state_reg == ST_REM)
            rem_reg <= rem_sat;
        if (state_reg == ST_OUT)
        begin
            out_reg <= {2'd0, cross_reg[30:0], mark_reg[30:0], rem_reg[31:0], gone_reg[30:0],
                        step_reg[30:0], nv_reg[30:0], ps_reg,
                        16'((period >> 1) + (period >> 2)), period[15:0]};
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb_stepper_ramp_period_generator.sv =====
// ----------------------------------------------------------------------------
// Stepper ramp period generator testbench
// Drives timer-tick beats with directed and random steering gains through a
// series of ramp set-ups written over the configuration channel, with random
// gaps and stalls on both streams. A scoreboard class predicts each result beat
// and checks all nine packed fields.
// ----------------------------------------------------------------------------
`default_nettype none

class ramp_scoreboard;
    localparam logic [63:0] P_MAX = 64'(srpg_pkg::PERIOD_MAX_DEF);
    localparam logic [63:0] P_MIN = 64'(srpg_pkg::PERIOD_MIN_DEF);

    logic [63:0] tgt_vel, accel, dec_vel, step_len, tick_per;
    longint      move_dist, dec_dist;
    logic [63:0] nxt_per, nxt_vel, cur_tgt, gone_odo, mark_odo, cross_odo;
    int unsigned presc;
    bit          armed;
    logic [223:0] pending[$];
    int          errors;
    int          checked;

    function new();
        tgt_vel = 0; accel = 0; move_dist = 0; dec_dist = 0;
        dec_vel = 0; step_len = 0; tick_per = 1;
        nxt_per = P_MAX << 14;
        nxt_vel = 0; cur_tgt = 0; presc = 0; armed = 0;
        gone_odo = 0; mark_odo = 0; cross_odo = 0;
        errors = 0; checked = 0;
    endfunction

    function logic [63:0] clip(logic [63:0] v, logic [63:0] top);
        return (v > top) ? top : v;
    endfunction

    function logic [63:0] odo_sum(logic [63:0] odo, logic [63:0] lim, logic [63:0] add);
        if (odo > lim)
            return odo;
        return clip(odo + add, srpg_pkg::M31);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            srpg_pkg::REG_TARGET_VEL:
            begin
                tgt_vel = {33'd0, d[30:0]};
                cur_tgt = tgt_vel;
            end
            srpg_pkg::REG_ACCEL:      accel = {33'd0, d[30:0]};
            srpg_pkg::REG_MOVE_DIST:  move_dist = longint'($signed(d));
            srpg_pkg::REG_DECEL_DIST:
            begin
                dec_dist = longint'($signed(d));
                armed = 1;
            end
            srpg_pkg::REG_DECEL_VEL:  dec_vel = {33'd0, d[30:0]};
            srpg_pkg::REG_STEP_LEN:   step_len = {33'd0, d[30:0]};
            srpg_pkg::REG_TICK_PER:   tick_per = {48'd0, d[15:0]};
            default: ;
        endcase
    endfunction

    function void note_tick(logic [30:0] gain);
        logic [63:0] scale, np, nv, pts, v, a, t, dv, pnt, ph, hi, lo, period, x, stp;
        logic [223:0] exp_beat;
        int unsigned ck;
        bit rising;
        longint rem;
        ck = presc;
        scale = step_len * 64'd10000;
        np = nxt_per;
        nv = nxt_vel;
        if (nv != cur_tgt)
        begin
            rising = nv < cur_tgt;
            pts = ((np << 14) / srpg_pkg::TEN_K_Q14) << 3 << ck;
            v = (pts == 0) ? srpg_pkg::M31 : clip((scale << 17) / pts, srpg_pkg::M31);
            a = (accel << 15) / srpg_pkg::TEN_K_Q15;
            t = (tick_per << 30) / srpg_pkg::TEN_K_Q15;
            dv = (a * t) >> 13;
            if (rising)
            begin
                nv = v + dv;
                if (nv >= cur_tgt)
                    nv = cur_tgt;
            end
            else
                nv = (v <= dv + cur_tgt) ? cur_tgt : v - dv;
            if (nv == 0)
                np = P_MAX << 14;
            else
            begin
                pnt = clip((scale << 17) / nv, srpg_pkg::M32);
                np = clip(((srpg_pkg::TEN_K_Q13 >> ck) * pnt) >> 16, srpg_pkg::M32);
            end
            if (rising)
            begin
                if (np <= (P_MIN << 14))
                begin
                    np = P_MIN << 14;
                    if (ck > 0)
                    begin
                        ck--;
                        np = np << 1;
                    end
                end
            end
            else if (np >= (P_MAX << 14))
            begin
                np = P_MAX << 14;
                if (ck < srpg_pkg::PRESCALE_TOP_DEF)
                begin
                    ck++;
                    np = np >> 1;
                end
            end
            nxt_per = np;
            nxt_vel = nv;
            presc = ck & 7;
        end
        ph = (np * {33'd0, gain}) >> 18;
        hi = P_MAX << 13;
        lo = (P_MIN << 13) >> ck;
        if (ph >= hi)
            ph = hi;
        else if (ph <= lo)
            ph = lo;
        period = (ph >> 13) & 64'hFFFF;
        x = (np == 0) ? srpg_pkg::M31 : clip((tick_per << 28) / np, srpg_pkg::M31);
        x = x >> ck;
        stp = clip((step_len * x) >> 14, srpg_pkg::M31);
        mark_odo  = odo_sum(mark_odo, srpg_pkg::MARK_LIMIT, stp);
        cross_odo = odo_sum(cross_odo, srpg_pkg::CROSS_LIMIT, stp >> 2);
        gone_odo  = odo_sum(gone_odo, srpg_pkg::GONE_LIMIT, stp >> 2);
        rem = move_dist - longint'(gone_odo << 2);
        if (rem > 64'sd2147483647)
            rem = 64'sd2147483647;
        if (rem < -64'sd2147483648)
            rem = -64'sd2147483648;
        if (armed && dec_dist >= rem)
        begin
            cur_tgt = dec_vel;
            armed = 0;
        end
        exp_beat = '0;
        exp_beat[15:0]    = period[15:0];
        exp_beat[31:16]   = (period[15:0] >> 1) + (period[15:0] >> 2);
        exp_beat[34:32]   = presc[2:0];
        exp_beat[65:35]   = nxt_vel[30:0];
        exp_beat[96:66]   = stp[30:0];
        exp_beat[127:97]  = gone_odo[30:0];
        exp_beat[159:128] = rem[31:0];
        exp_beat[190:160] = mark_odo[30:0];
        exp_beat[221:191] = cross_odo[30:0];
        pending.push_back(exp_beat);
    endfunction

    function void check_result(logic [223:0] got);
        int lsb[9] = '{0, 16, 32, 35, 66, 97, 128, 160, 191};
        int wid[9] = '{16, 16, 3, 31, 31, 31, 32, 31, 31};
        string fname[9] = '{"pwm_period", "pwm_compare", "prescale", "velocity",
                            "step_distance", "travelled", "remaining",
                            "mark_distance", "cross_distance"};
        logic [223:0] exp_beat;
        logic [31:0] e, g, mask;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: result beat with nothing expected: %h", got);
            return;
        end
        exp_beat = pending.pop_front();
        checked++;
        for (int i = 0; i < 9; i++)
        begin
            mask = (wid[i] == 32) ? 32'hFFFF_FFFF : ((32'd1 << wid[i]) - 1);
            e = 32'(exp_beat >> lsb[i]) & mask;
            g = 32'(got >> lsb[i]) & mask;
            if (e !== g)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: beat %0d %s expected %h got %h",
                             checked, fname[i], e, g);
            end
        end
    endfunction
endclass

module tb_stepper_ramp_period_generator;
    import srpg_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // steering_gain[30:0]
    logic         m_tvalid;
    logic         m_tready;
    // pwm_period, pwm_compare, prescale, velocity, step_distance, travelled,
    // remaining, mark_distance, cross_distance (from bit 0 up)
    logic [223:0] m_tdata;

    ramp_scoreboard sb;
    int unsigned    cycles = 0;
    int unsigned    ticks_sent;
    int unsigned    setups;
    bit             stall_free;

    stepper_ramp_period_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // random receiver back-pressure, with stall-free stretches
    initial
    begin
        int unsigned hold;
        hold = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_free || hold == 0)
            begin
                m_tready = 1'b1;
                if (!stall_free)
                begin
                    case ($urandom_range(0, 9))
                        0, 1: hold = $urandom_range(1, 3);
                        2:    hold = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : 0;
                        default: hold = 0;
                    endcase
                end
            end
            else
            begin
                m_tready = 1'b0;
                hold--;
            end
        end
    end

    function automatic logic [31:0] wide_rand(int top_bits);
        int k;
        k = $urandom_range(0, top_bits);
        if (k == 0)
            return 32'd0;
        return $urandom & ((k >= 32) ? 32'hFFFF_FFFF : ((32'd1 << k) - 1));
    endfunction

    function automatic logic [31:0] gain_rand();
        case ($urandom_range(0, 9))
            0:       return wide_rand(31);
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            default: return 32'd131072 + $urandom_range(0, 65535) - 32'd32768;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_tick(logic [31:0] gain);
        int unsigned gap;
        case ($urandom_range(0, 9))
            0, 1:    gap = $urandom_range(1, 4);
            2:       gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : 0;
            default: gap = 0;
        endcase
        if (stall_free)
            gap = 0;
        repeat (gap) @(negedge clk);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, gain[30:0]};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_tick(gain[30:0]);
        ticks_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_ticks(int n, bit pause_mid);
        for (int i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
                drain();
            send_tick(gain_rand());
        end
    endtask

    // a full ramp set-up with random content, or a partial rewrite
    task automatic random_setup(bit full);
        logic [31:0] tv, st;
        tv = wide_rand(31);
        st = wide_rand(20);
        if (full || $urandom_range(0, 1))
            write_reg(REG_STEP_LEN, ($urandom_range(0, 15) == 0) ? 32'h7FFF_FFFF : st);
        if (full || $urandom_range(0, 1))
            write_reg(REG_ACCEL, ($urandom_range(0, 9) == 0) ? 32'h7FFF_FFFF : wide_rand(31));
        if (full || $urandom_range(0, 1))
            write_reg(REG_TICK_PER, ($urandom_range(0, 9) == 0) ?
                      32'($urandom_range(0, 1) * 65535) : wide_rand(16));
        if (full || $urandom_range(0, 1))
            write_reg(REG_MOVE_DIST, ($urandom_range(0, 1)) ? wide_rand(32) : -wide_rand(31));
        if (full || $urandom_range(0, 1))
            write_reg(REG_DECEL_VEL, wide_rand(31));
        if (full || $urandom_range(0, 2) != 0)
            write_reg(REG_DECEL_DIST, ($urandom_range(0, 1)) ? wide_rand(32) : -wide_rand(31));
        if (full || $urandom_range(0, 2) != 0)
            write_reg(REG_TARGET_VEL, ($urandom_range(0, 9) == 0) ? 32'h7FFF_FFFF : tv);
        setups++;
    endtask

    initial
    begin
        sb = new();
        ticks_sent = 0;
        setups = 0;
        stall_free = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // standstill at reset values
        send_tick(32'd0);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'd131072);
        drain();

        // zero tick interval: no ramp, no distance
        write_reg(REG_STEP_LEN, 32'd13107);
        write_reg(REG_TICK_PER, 32'd0);
        write_reg(REG_ACCEL, 32'd3276800);
        write_reg(REG_TARGET_VEL, 32'd6553600);
        send_tick(32'd131072);
        send_tick(32'd131072);
        drain();

        // extreme registers: fast ramp to top speed
        write_reg(REG_TICK_PER, 32'd65535);
        write_reg(REG_ACCEL, 32'h7FFF_FFFF);
        write_reg(REG_STEP_LEN, 32'h7FFF_FFFF);
        write_reg(REG_MOVE_DIST, 32'h7FFF_FFFF);
        write_reg(REG_DECEL_VEL, 32'd0);
        write_reg(REG_DECEL_DIST, 32'h8000_0000);
        write_reg(REG_TARGET_VEL, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_tick(i[0] ? 32'h7FFF_FFFF : 32'd1);
        drain();

        // short move: decel trigger fires at once, ramp down to standstill
        write_reg(REG_STEP_LEN, 32'd1000);
        write_reg(REG_MOVE_DIST, 32'h8000_0000);
        write_reg(REG_DECEL_DIST, 32'h7FFF_FFFF);
        for (int i = 0; i < 10; i++)
            send_tick(32'd131072);
        drain();

        for (int p = 0; p < 20; p++)
        begin
            random_setup(p == 0 || $urandom_range(0, 2) == 0);
            stall_free = (p % 5 == 4);
            run_ticks($urandom_range(60, 110), p == 1 || $urandom_range(0, 3) == 0);
            stall_free = 1'b0;
            drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.errors += sb.pending.size();
        $display("Run covered %0d tick beats over %0d register set-ups, %0d results checked.",
                 ticks_sent, setups, sb.checked);
        if (sb.errors > 10)
            $display("%0d mismatches in total", sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
